FILE: design/psavs_pkg.sv
`timescale 1ns / 1ps

package psavs_pkg;

    // Register map and widths
    localparam int unsigned DelayWidth = 16;
    localparam int unsigned PhaseWidth = 4;
    localparam int unsigned AddrWidth  = 5;
    localparam int unsigned DataWidth  = 32;
    localparam int unsigned IdxWidth   = 3;

    localparam logic [IdxWidth-1:0] REG_RELAY_TEST = 3'd0;
    localparam logic [IdxWidth-1:0] REG_PURGE      = 3'd1;
    localparam logic [IdxWidth-1:0] REG_PRODUCTION = 3'd2;
    localparam logic [IdxWidth-1:0] REG_FLUSH      = 3'd3;
    localparam logic [IdxWidth-1:0] REG_PRECHARGE  = 3'd4;

    localparam logic [DelayWidth-1:0] RELAY_TEST_RESET = 16'd100;
    localparam logic [DelayWidth-1:0] PURGE_RESET      = 16'd1000;
    localparam logic [DelayWidth-1:0] PRODUCTION_RESET = 16'd4000;
    localparam logic [DelayWidth-1:0] FLUSH_RESET      = 16'd500;
    localparam logic [DelayWidth-1:0] PRECHARGE_RESET  = 16'd500;

    // Phase codes
    localparam logic [PhaseWidth-1:0] PH_RELAY_A    = 4'd0;
    localparam logic [PhaseWidth-1:0] PH_RELAY_B    = 4'd1;
    localparam logic [PhaseWidth-1:0] PH_RELAY_PRE  = 4'd2;
    localparam logic [PhaseWidth-1:0] PH_RELAY_HOLD = 4'd3;
    localparam logic [PhaseWidth-1:0] PH_PURGE      = 4'd4;
    localparam logic [PhaseWidth-1:0] PH_FAN_WAIT   = 4'd5;
    localparam logic [PhaseWidth-1:0] PH_A_CHARGE   = 4'd6;
    localparam logic [PhaseWidth-1:0] PH_A_FLUSH    = 4'd7;
    localparam logic [PhaseWidth-1:0] PH_AB_PRE_1   = 4'd8;
    localparam logic [PhaseWidth-1:0] PH_B_CHARGE   = 4'd9;
    localparam logic [PhaseWidth-1:0] PH_B_FLUSH    = 4'd10;
    localparam logic [PhaseWidth-1:0] PH_AB_PRE_2   = 4'd11;

    typedef struct packed {
        logic [DelayWidth-1:0] relay_test_ticks;
        logic [DelayWidth-1:0] purge_ticks;
        logic [DelayWidth-1:0] production_ticks;
        logic [DelayWidth-1:0] flush_ticks;
        logic [DelayWidth-1:0] precharge_ticks;
    } cfg_t;

    typedef struct packed {
        logic                  valve_a;
        logic                  valve_b;
        logic                  valve_precharge;
        logic                  fan_on;
        logic [PhaseWidth-1:0] phase_index;
    } result_t;

    // Valve pattern per phase: bit0 = A, bit1 = B, bit2 = precharge
    function automatic logic [2:0] valve_map(input logic [PhaseWidth-1:0] phase);
        logic [2:0] v;
        begin
            unique case (phase)
                PH_RELAY_A:  v = 3'b001;
                PH_RELAY_B:  v = 3'b011;
                PH_A_CHARGE: v = 3'b001;
                PH_A_FLUSH:  v = 3'b101;
                PH_B_CHARGE: v = 3'b010;
                PH_B_FLUSH:  v = 3'b110;
                default:     v = 3'b111;
            endcase
            return v;
        end
    endfunction

    // Delay of a phase, zero taken as one tick
    function automatic logic [DelayWidth-1:0] phase_delay(input cfg_t cfg,
                                                          input logic [PhaseWidth-1:0] phase);
        logic [DelayWidth-1:0] d;
        begin
            unique case (phase)
                PH_RELAY_A, PH_RELAY_B, PH_RELAY_PRE, PH_RELAY_HOLD, PH_FAN_WAIT:
                    d = cfg.relay_test_ticks;
                PH_PURGE:
                    d = cfg.purge_ticks;
                PH_A_CHARGE, PH_B_CHARGE:
                    d = cfg.production_ticks;
                PH_A_FLUSH, PH_B_FLUSH:
                    d = cfg.flush_ticks;
                default:
                    d = cfg.precharge_ticks;
            endcase
            return (d == '0) ? DelayWidth'(1) : d;
        end
    endfunction

endpackage

FILE: design/psa_valve_sequencer_unit.sv
`timescale 1ns / 1ps

// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------
// in       | in_valid / in_stall     | tick
// out      | out_valid / out_stall   | valve_a, valve_b, valve_precharge,
//          |                         | fan_on, phase_index
// cfg      | APB psel/penable/pwrite | paddr, pwdata, prdata (pready tied high)
//
// One request per cycle while out_stall is low; each passes the input register, then the result register.
// The phase update is one 16-bit increment and compare in the step between them.
// Reset gives the default delays, phase 0, count 0 and fan off.
// A stall on the output holds the result register and backs up into in_stall.

module psa_valve_sequencer_unit
    import psavs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AddrWidth-1:0]  paddr,
    input  logic [DataWidth-1:0]  pwdata,
    output logic [DataWidth-1:0]  prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  tick,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  valve_a,
    output logic                  valve_b,
    output logic                  valve_precharge,
    output logic                  fan_on,
    output logic [PhaseWidth-1:0] phase_index
);

    cfg_t    cfg;
    result_t result;
    result_t res_reg;
    logic    in_valid_reg;
    logic    tick_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    step_en;
    logic    in_take;

    psavs_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psavs_seq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .tick    (tick_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // Move a request forward when the result register is free or draining
    assign out_free = ~out_valid_reg | ~out_stall;
    assign step_en  = in_valid_reg & out_free;
    assign in_stall = in_valid_reg & ~out_free;
    assign in_take  = in_valid & ~in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (~in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            tick_reg <= tick;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= result;
        end
    end

    assign out_valid       = out_valid_reg;
    assign valve_a         = res_reg.valve_a;
    assign valve_b         = res_reg.valve_b;
    assign valve_precharge = res_reg.valve_precharge;
    assign fan_on          = res_reg.fan_on;
    assign phase_index     = res_reg.phase_index;

endmodule

FILE: design/psavs_cfg_regs.sv
`timescale 1ns / 1ps

module psavs_cfg_regs
    import psavs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t                  cfg_reg;
    logic                  wr_en;
    logic [IdxWidth-1:0]   reg_idx;
    logic [DelayWidth-1:0] wdata;
    logic [DelayWidth-1:0] rdata;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[AddrWidth-1:2];
    assign wdata   = pwdata[DelayWidth-1:0];
    assign cfg     = cfg_reg;

    // Write the addressed delay register, drop writes beyond the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.relay_test_ticks <= RELAY_TEST_RESET;
            cfg_reg.purge_ticks      <= PURGE_RESET;
            cfg_reg.production_ticks <= PRODUCTION_RESET;
            cfg_reg.flush_ticks      <= FLUSH_RESET;
            cfg_reg.precharge_ticks  <= PRECHARGE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_RELAY_TEST: cfg_reg.relay_test_ticks <= wdata;
                REG_PURGE:      cfg_reg.purge_ticks      <= wdata;
                REG_PRODUCTION: cfg_reg.production_ticks <= wdata;
                REG_FLUSH:      cfg_reg.flush_ticks      <= wdata;
                REG_PRECHARGE:  cfg_reg.precharge_ticks  <= wdata;
                default:        ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_RELAY_TEST: rdata = cfg_reg.relay_test_ticks;
            REG_PURGE:      rdata = cfg_reg.purge_ticks;
            REG_PRODUCTION: rdata = cfg_reg.production_ticks;
            REG_FLUSH:      rdata = cfg_reg.flush_ticks;
            REG_PRECHARGE:  rdata = cfg_reg.precharge_ticks;
            default:        rdata = '0;
        endcase
    end

    assign prdata = {{(DataWidth-DelayWidth){1'b0}}, rdata};

endmodule

FILE: design/psavs_seq_core.sv
`timescale 1ns / 1ps

module psavs_seq_core
    import psavs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step_en,
    input  logic    tick,
    input  cfg_t    cfg,
    output result_t result
);

    logic [PhaseWidth-1:0] phase_reg;
    logic [PhaseWidth-1:0] phase_next;
    logic [DelayWidth-1:0] count_reg;
    logic [DelayWidth-1:0] count_next;
    logic                  fan_reg;
    logic                  fan_next;
    logic [DelayWidth-1:0] count_inc;
    logic                  phase_done;
    logic [2:0]            valves;

    // Count the tick and compare against the current phase delay
    assign count_inc  = count_reg + DelayWidth'(1);
    assign phase_done = (count_inc >= phase_delay(cfg, phase_reg));

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        fan_next   = fan_reg;
        if (tick)
        begin
            count_next = count_inc;
            if (phase_done)
            begin
                count_next = '0;
                if (phase_reg == PH_FAN_WAIT)
                begin
                    fan_next = 1'b1;
                end
                if (phase_reg >= PH_AB_PRE_2)
                begin
                    phase_next = PH_A_CHARGE;
                end
                else
                begin
                    phase_next = phase_reg + PhaseWidth'(1);
                end
            end
        end
    end

    // Advance state once per request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RELAY_A;
            count_reg <= '0;
            fan_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            fan_reg   <= fan_next;
        end
    end

    // Outputs after this request is applied
    assign valves                 = valve_map(phase_next);
    assign result.valve_a         = valves[0];
    assign result.valve_b         = valves[1];
    assign result.valve_precharge = valves[2];
    assign result.fan_on          = fan_next;
    assign result.phase_index     = phase_next;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import psavs_pkg::*;

    localparam int unsigned RegCount    = 5;
    localparam int unsigned CyclesLimit = 200000;
    localparam int unsigned SegCount    = 12;
    localparam int unsigned SegItems    = 150;
    localparam int unsigned HoldCycles  = 80;
    localparam int unsigned MaxReports  = 10;
    localparam int unsigned QuietSeg    = 4;
    localparam int unsigned HoldSeg     = 6;
    localparam int unsigned PauseSeg    = 8;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic                  tk;
        logic [IdxWidth-1:0]   idx;
        logic [DataWidth-1:0]  data;
        bit                    has_exp;
        result_t               exp;
    } stim_row_t;

    // DUT ports
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [AddrWidth-1:0]  paddr     = '0;
    logic [DataWidth-1:0]  pwdata    = '0;
    logic [DataWidth-1:0]  prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  tick      = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  valve_a;
    logic                  valve_b;
    logic                  valve_precharge;
    logic                  fan_on;
    logic [PhaseWidth-1:0] phase_index;

    // Sequencer prediction state
    logic [DelayWidth-1:0] seq_delay [RegCount];
    logic [PhaseWidth-1:0] seq_phase;
    logic [DelayWidth-1:0] seq_count;
    logic                  seq_fan;
    result_t               pending_outputs [$];
    result_t               head_outputs;

    // Bookkeeping
    int unsigned errors          = 0;
    int unsigned requests_sent   = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned cycles          = 0;
    logic [15:0] phases_seen     = '0;
    bit          no_gaps         = 1'b0;
    int unsigned hold_req        = 0;
    int unsigned hold_seen       = 0;
    int unsigned hold_left       = 0;
    stim_row_t   dir_rows [$];

    psa_valve_sequencer_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .tick            (tick),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .valve_a         (valve_a),
        .valve_b         (valve_b),
        .valve_precharge (valve_precharge),
        .fan_on          (fan_on),
        .phase_index     (phase_index)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void report_mismatch(input string msg);
        errors++;
        if (errors <= MaxReports)
            $display("MISMATCH: %s", msg);
    endfunction

    // Delay of the current phase; a zero register counts as one tick
    function automatic logic [DelayWidth-1:0] phase_ticks(input logic [PhaseWidth-1:0] ph);
        logic [DelayWidth-1:0] d;
        case (ph)
            PH_RELAY_A, PH_RELAY_B, PH_RELAY_PRE, PH_RELAY_HOLD, PH_FAN_WAIT:
                d = seq_delay[REG_RELAY_TEST];
            PH_PURGE:
                d = seq_delay[REG_PURGE];
            PH_A_CHARGE, PH_B_CHARGE:
                d = seq_delay[REG_PRODUCTION];
            PH_A_FLUSH, PH_B_FLUSH:
                d = seq_delay[REG_FLUSH];
            default:
                d = seq_delay[REG_PRECHARGE];
        endcase
        if (d == '0)
            d = DelayWidth'(1);
        return d;
    endfunction

    // Apply one request to the sequencer state and return the valve outputs
    function automatic result_t step_sequencer(input logic tk);
        result_t r;
        if (tk)
        begin
            seq_count = seq_count + 1'b1;
            if (seq_count >= phase_ticks(seq_phase))
            begin
                seq_count = '0;
                if (seq_phase == PH_FAN_WAIT)
                    seq_fan = 1'b1;
                if (seq_phase >= PH_AB_PRE_2)
                    seq_phase = PH_A_CHARGE;
                else
                    seq_phase = seq_phase + 1'b1;
            end
        end
        case (seq_phase)
            PH_RELAY_A, PH_A_CHARGE: {r.valve_a, r.valve_b, r.valve_precharge} = 3'b100;
            PH_RELAY_B:              {r.valve_a, r.valve_b, r.valve_precharge} = 3'b110;
            PH_A_FLUSH:              {r.valve_a, r.valve_b, r.valve_precharge} = 3'b101;
            PH_B_CHARGE:             {r.valve_a, r.valve_b, r.valve_precharge} = 3'b010;
            PH_B_FLUSH:              {r.valve_a, r.valve_b, r.valve_precharge} = 3'b011;
            default:                 {r.valve_a, r.valve_b, r.valve_precharge} = 3'b111;
        endcase
        r.fan_on      = seq_fan;
        r.phase_index = seq_phase;
        return r;
    endfunction

    function automatic logic [DelayWidth-1:0] pick_delay();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 15)
            return '1;
        if (r < 18)
            return DelayWidth'($urandom);
        return DelayWidth'($urandom_range(6, 1));
    endfunction

    function automatic stim_row_t tick_row(input logic tk);
        stim_row_t row;
        row = '{ROW_ITEM, tk, '0, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t tick_row_exp(input logic tk, input result_t exp);
        stim_row_t row;
        row = '{ROW_ITEM, tk, '0, '0, 1'b1, exp};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [IdxWidth-1:0] idx,
                                          input logic [DataWidth-1:0] data);
        stim_row_t row;
        row = '{ROW_CFG, 1'b0, idx, data, 1'b0, '0};
        return row;
    endfunction

    // Offer one request, hold it until accepted, record the expected outputs
    task automatic send_request(input logic tk, input bit has_exp, input result_t exp);
        result_t pred;
        if (!no_gaps && $urandom_range(99) < 20)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        in_valid = 1'b1;
        tick     = tk;
        do
            @(posedge clk);
        while (in_stall);
        pred = step_sequencer(tk);
        pending_outputs.push_back(has_exp ? exp : pred);
        requests_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected result has come out
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [IdxWidth-1:0] idx,
                              input logic [DataWidth-1:0] data,
                              output logic [DataWidth-1:0] rd);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write a register, track it, and read it back where it exists
    task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [DataWidth-1:0] data);
        logic [DataWidth-1:0] rd;
        apb_access(1'b1, idx, data, rd);
        reg_writes++;
        if (idx < RegCount)
        begin
            seq_delay[idx] = data[DelayWidth-1:0];
            apb_access(1'b0, idx, '0, rd);
            if (rd !== DataWidth'(seq_delay[idx]))
                report_mismatch($sformatf("register %0d read %h, expected %h",
                                          idx, rd, DataWidth'(seq_delay[idx])));
        end
    endtask

    // Receiver stall: random, quiet, or a long hold on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HoldCycles;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = !no_gaps && ($urandom_range(99) < 20);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_checked++;
            phases_seen[phase_index] = 1'b1;
            if (pending_outputs.size() == 0)
                report_mismatch($sformatf("unexpected result phase %0d", phase_index));
            else
            begin
                head_outputs = pending_outputs.pop_front();
                if (valve_a !== head_outputs.valve_a || valve_b !== head_outputs.valve_b ||
                    valve_precharge !== head_outputs.valve_precharge ||
                    fan_on !== head_outputs.fan_on ||
                    phase_index !== head_outputs.phase_index)
                    report_mismatch($sformatf(
                        "exp a%b b%b p%b fan%b ph%0d, got a%b b%b p%b fan%b ph%0d",
                        head_outputs.valve_a, head_outputs.valve_b,
                        head_outputs.valve_precharge, head_outputs.fan_on,
                        head_outputs.phase_index, valve_a, valve_b, valve_precharge,
                        fan_on, phase_index));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CyclesLimit)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_outputs.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        seq_delay[REG_RELAY_TEST] = RELAY_TEST_RESET;
        seq_delay[REG_PURGE]      = PURGE_RESET;
        seq_delay[REG_PRODUCTION] = PRODUCTION_RESET;
        seq_delay[REG_FLUSH]      = FLUSH_RESET;
        seq_delay[REG_PRECHARGE]  = PRECHARGE_RESET;
        seq_phase = PH_RELAY_A;
        seq_count = '0;
        seq_fan   = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed walk: start-up, zero delays, full loop, shortened delays
        dir_rows.push_back(tick_row_exp(1'b0, result_t'{1'b1, 1'b0, 1'b0, 1'b0, PH_RELAY_A}));
        dir_rows.push_back(tick_row_exp(1'b1, result_t'{1'b1, 1'b0, 1'b0, 1'b0, PH_RELAY_A}));
        dir_rows.push_back(cfg_row(REG_RELAY_TEST, 32'h0000_0000));
        dir_rows.push_back(tick_row_exp(1'b1, result_t'{1'b1, 1'b1, 1'b0, 1'b0, PH_RELAY_B}));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(cfg_row(REG_PURGE, 32'h0000_0000));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row_exp(1'b0, result_t'{1'b1, 1'b1, 1'b1, 1'b0, PH_FAN_WAIT}));
        dir_rows.push_back(tick_row_exp(1'b1, result_t'{1'b1, 1'b0, 1'b0, 1'b1, PH_A_CHARGE}));
        dir_rows.push_back(cfg_row(REG_PRODUCTION, 32'hFFFF_FFFF));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(cfg_row(REG_PRODUCTION, 32'h0000_0001));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(cfg_row(REG_FLUSH, 32'h0000_0000));
        dir_rows.push_back(cfg_row(REG_PRECHARGE, 32'h0000_FFFF));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(cfg_row(REG_PRECHARGE, 32'h0000_0001));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row(1'b1));
        dir_rows.push_back(tick_row_exp(1'b1, result_t'{1'b1, 1'b0, 1'b0, 1'b1, PH_A_CHARGE}));
        dir_rows.push_back(tick_row(1'b0));
        dir_rows.push_back(cfg_row(IdxWidth'(RegCount), 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row('1, 32'h0000_0000));
        dir_rows.push_back(tick_row(1'b1));

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].kind == ROW_CFG)
            begin
                drain_results();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
            end
            else
                send_request(dir_rows[k].tk, dir_rows[k].has_exp, dir_rows[k].exp);
        end

        // Random segments, each with a fresh set of delays
        for (int seg = 0; seg < SegCount; seg++)
        begin
            drain_results();
            for (int r = 0; r < RegCount; r++)
                write_reg(IdxWidth'(r), {16'($urandom), pick_delay()});
            if ($urandom_range(2) == 0)
                write_reg(IdxWidth'($urandom_range((1 << IdxWidth) - 1, RegCount)), $urandom);
            no_gaps = (seg == QuietSeg);
            if (seg == HoldSeg)
                hold_req++;
            for (int i = 0; i < SegItems; i++)
            begin
                // pause the sender until everything has drained
                if (seg == PauseSeg && i == SegItems / 2)
                    drain_results();
                send_request($urandom_range(99) < 75, 1'b0, '0);
            end
            no_gaps = 1'b0;
        end

        drain_results();

        $display("Covered %0d requests, %0d results checked, %0d register writes.",
                 requests_sent, results_checked, reg_writes);
        $display("Phase codes reached %b; long output hold and input drain pause included.",
                 phases_seen);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
design/psavs_pkg.sv
design/psavs_cfg_regs.sv
design/psavs_seq_core.sv
design/psa_valve_sequencer_unit.sv
sim/tb_top.sv
